[hw/rtl/utf8v_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types and byte constants for the UTF-8 text validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam int unsigned CpW = 21;

  // Word kinds carried on tuser
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_EOT  = 1'b1;

  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_DEL   = 8'h7F;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_HI   = 8'hEF;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;

  localparam logic [CpW-1:0] CP_MIN3     = 21'h000800;
  localparam logic [CpW-1:0] CP_MIN4     = 21'h010000;
  localparam logic [CpW-1:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [CpW-1:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [CpW-1:0] CP_MAX      = 21'h10FFFF;

  typedef struct packed {
    logic [1:0]     bytes_pending;
    logic [1:0]     sequence_length;
    logic [CpW-1:0] code_point_acc;
    logic           error_seen;
  } text_state_t;

endpackage
`default_nettype wire

[hw/rtl/utf8v_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf8v_step
// Next-state logic for one word: lead decode, continuation build-up and
// code point checks, plus the end-of-text verdict.
// ----------------------------------------------------------------------------
module utf8v_step (
  input  wire logic                   allow_newlines,
  input  wire logic                   opcode,
  input  wire logic [7:0]             data_byte,
  input  wire utf8v_pkg::text_state_t state_cur,
  output utf8v_pkg::text_state_t      state_nxt,
  output logic                        has_result,
  output logic                        text_valid
);
  import utf8v_pkg::*;

  logic           ws_ok;
  logic           ascii_ok;
  logic [CpW-1:0] cp_shift;
  logic [1:0]     pend_dec;
  logic           overlong;
  logic           surrogate;
  logic           too_big;

  always_comb begin
    ws_ok    = allow_newlines &&
               (data_byte == BYTE_LF || data_byte == BYTE_CR || data_byte == BYTE_TAB);
    ascii_ok = !((data_byte < BYTE_SPACE || data_byte == BYTE_DEL) && !ws_ok);
    cp_shift = {state_cur.code_point_acc[CpW-7:0], data_byte[5:0]};
    pend_dec = state_cur.bytes_pending - 2'd1;
    overlong = (state_cur.sequence_length == 2'd2 && cp_shift < CP_MIN3) ||
               (state_cur.sequence_length == 2'd3 && cp_shift < CP_MIN4);
    surrogate = (cp_shift >= CP_SURR_LO) && (cp_shift <= CP_SURR_HI);
    too_big   = cp_shift > CP_MAX;

    state_nxt  = state_cur;
    has_result = 1'b0;
    text_valid = !state_cur.error_seen && (state_cur.bytes_pending == 2'd0);

    if (opcode == OP_EOT) begin
      has_result = 1'b1;
      state_nxt  = '0;
    end else if (state_cur.error_seen) begin
      // drop bytes until end of text
      state_nxt = state_cur;
    end else if (state_cur.bytes_pending == 2'd0) begin
      if (data_byte[7] == 1'b0) begin
        if (!ascii_ok) begin
          state_nxt.error_seen = 1'b1;
        end
      end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
        state_nxt.sequence_length = 2'd1;
        state_nxt.bytes_pending   = 2'd1;
        state_nxt.code_point_acc  = {{(CpW-5){1'b0}}, data_byte[4:0]};
      end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
        state_nxt.sequence_length = 2'd2;
        state_nxt.bytes_pending   = 2'd2;
        state_nxt.code_point_acc  = {{(CpW-4){1'b0}}, data_byte[3:0]};
      end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
        state_nxt.sequence_length = 2'd3;
        state_nxt.bytes_pending   = 2'd3;
        state_nxt.code_point_acc  = {{(CpW-3){1'b0}}, data_byte[2:0]};
      end else begin
        state_nxt.error_seen = 1'b1;
      end
    end else if (data_byte[7:6] != 2'b10) begin
      state_nxt.error_seen = 1'b1;
    end else begin
      state_nxt.code_point_acc = cp_shift;
      state_nxt.bytes_pending  = pend_dec;
      if (pend_dec == 2'd0) begin
        // sequence complete: check the finished code point
        if (overlong || surrogate || too_big) begin
          state_nxt.error_seen = 1'b1;
        end
        state_nxt.sequence_length = 2'd0;
        state_nxt.code_point_acc  = '0;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/utf8_text_validator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_text_validator
// Strict UTF-8 text checker, one byte per word, verdict at end of text.
// ----------------------------------------------------------------------------
// Send the text one byte per word with in_tuser = 0, then one word with
// in_tuser = 1 to mark end of text; that word returns a single out_tdata[0]
// verdict (1 = valid UTF-8 with no control characters) and clears the text
// state. A new word is accepted every clock while nothing stalls:
// a word sits in the input register while the step logic updates the text
// state, and a verdict waits in the output register without blocking data
// bytes behind it. Only an end-of-text word stalls, and only while the
// previous verdict is still unread. Write cfg_wr_data = 1 to accept LF, CR
// and TAB; write it only while no text is in flight.
module utf8_text_validator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tuser,   // [0] opcode
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [0] text_valid, [7:1] zero
);
  import utf8v_pkg::*;

  logic        allow_r;
  logic        item_valid_r;
  logic        item_op_r;
  logic [7:0]  item_byte_r;
  text_state_t state_r;
  text_state_t state_nxt;
  logic        out_valid_r;
  logic        out_bit_r;
  logic        has_result;
  logic        verdict;
  logic        stall;
  logic        advance;

  utf8v_step u_step (
    .allow_newlines (allow_r),
    .opcode         (item_op_r),
    .data_byte      (item_byte_r),
    .state_cur      (state_r),
    .state_nxt      (state_nxt),
    .has_result     (has_result),
    .text_valid     (verdict)
  );

  assign stall     = item_valid_r && has_result && out_valid_r && !out_tready;
  assign advance   = item_valid_r && !stall;
  assign in_tready = !item_valid_r || !stall;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_bit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_r <= 1'b0;
    end else if (cfg_wr_en) begin
      allow_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_op_r   <= in_tuser;
      item_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_bit_r <= verdict;
    end
  end

endmodule
`default_nettype wire
